// ===== rtl/core/tbql_pkg.sv =====
// Shared constants, codes and control types for the three-axis biquad low-pass.
package tbql_pkg;

  localparam int TBQL_SAMPLE_BITS     = 16;
  localparam int TBQL_COEF_FRAC_BITS  = 20;
  localparam int TBQL_STATE_FRAC_BITS = 8;
  localparam int TBQL_AXIS_COUNT      = 3;

  localparam int COEF_BITS     = 24;
  localparam int REG_COUNT     = 6;
  localparam int CFG_ADDR_BITS = 3;
  localparam int DIGIT_BITS    = 4;

  localparam logic [CFG_ADDR_BITS-1:0] REG_GAIN = 3'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_B0   = 3'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_B1   = 3'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_B2   = 3'd3;
  localparam logic [CFG_ADDR_BITS-1:0] REG_A1   = 3'd4;
  localparam logic [CFG_ADDR_BITS-1:0] REG_A2   = 3'd5;

  localparam logic signed [COEF_BITS-1:0] RST_GAIN = 24'sd38352;
  localparam logic signed [COEF_BITS-1:0] RST_B0   = 24'sd1048576;
  localparam logic signed [COEF_BITS-1:0] RST_B1   = 24'sd2097152;
  localparam logic signed [COEF_BITS-1:0] RST_B2   = 24'sd1048576;
  localparam logic signed [COEF_BITS-1:0] RST_A1   = -24'sd1458459;
  localparam logic signed [COEF_BITS-1:0] RST_A2   = 24'sd563289;

  // Multiply phases of one axis, in issue order
  localparam logic [2:0] PH_B0   = 3'd0;
  localparam logic [2:0] PH_B1   = 3'd1;
  localparam logic [2:0] PH_B2   = 3'd2;
  localparam logic [2:0] PH_GAIN = 3'd3;
  localparam logic [2:0] PH_A1   = 3'd4;
  localparam logic [2:0] PH_A2   = 3'd5;

  // Operand kinds, each with its own digit count
  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_SUM    = 2'd1;
  localparam logic [1:0] KIND_STATE  = 2'd2;

  typedef struct packed {
    logic       idle;
    logic       mul_load;
    logic       mul_step;
    logic       mul_last;
    logic [1:0] kind;
    logic [2:0] phase;
    logic       acc_add;
    logic       do_round;
    logic       do_finish;
    logic       do_push;
  } tbql_ctl_t;

endpackage

// ===== rtl/core/three_axis_biquad_lowpass.sv =====
// Top level: three-axis direct-form-I biquad low-pass with a shared serial multiplier.
//
// Usage:
//   in_*  : one item carries one signed sample per axis in in_tdata.
//   out_* : one item per input item, filtered value per axis in out_tdata,
//           out_tuser high when any axis saturated (state or output).
//   cfg_* : write gain, b0, b1, b2, a1, a2 (signed Q4.20) while idle;
//           indexes beyond the list are ignored.
// Timing: every product goes through one digit-serial multiplier, DIGIT_BITS
//   operand bits per cycle; a product runs over NX, NS or NY digits, the digit
//   counts of a sample, of the rounded feedforward sum and of a stored output.
//   Axes are worked one after the other, and an item is accepted only once the
//   last one has been pushed to the output register.
// in_tready is high whenever the sequencer is idle, also while a result still
//   waits in the output register. A stalled receiver holds the result there;
//   the next item's result then waits until that register is taken.
// Reset (rst_n low, synchronous) loads the default coefficients, clears the
//   filter history of all axes and drops any pending item.
module three_axis_biquad_lowpass #(
  parameter int SAMPLE_BITS     = tbql_pkg::TBQL_SAMPLE_BITS,
  parameter int COEF_FRAC_BITS  = tbql_pkg::TBQL_COEF_FRAC_BITS,
  parameter int STATE_FRAC_BITS = tbql_pkg::TBQL_STATE_FRAC_BITS,
  parameter int AXIS_COUNT      = tbql_pkg::TBQL_AXIS_COUNT
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // in_tdata: sample_x, sample_y, sample_z (one SAMPLE_BITS lane each), zero pad
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [((AXIS_COUNT*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // out_tdata: filtered_x, filtered_y, filtered_z (one lane each), zero pad
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [((AXIS_COUNT*SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  // out_tuser: clipped
  output logic                                    out_tuser,
  input  logic                                    cfg_we,
  input  logic [tbql_pkg::CFG_ADDR_BITS-1:0]      cfg_addr,
  input  logic [tbql_pkg::COEF_BITS-1:0]          cfg_wdata
);
  import tbql_pkg::*;

  localparam int SB   = SAMPLE_BITS;
  localparam int SFB  = STATE_FRAC_BITS;
  localparam int STW  = SB + SFB;
  localparam int CW   = COEF_BITS;
  localparam int D    = DIGIT_BITS;
  localparam int RSH  = COEF_FRAC_BITS - STATE_FRAC_BITS;
  localparam int SRW  = CW + SB + 3 - RSH;
  localparam int NX   = (SB + D - 1) / D;
  localparam int NY   = (STW + D - 1) / D;
  localparam int NS   = (SRW + D - 1) / D;
  localparam int NMAX = (NX > NY) ? ((NX > NS) ? NX : NS) : ((NY > NS) ? NY : NS);
  localparam int OPW  = NMAX * D;
  localparam int AW   = CW + D + 1 + OPW + 2;
  localparam int DW   = ((AXIS_COUNT * SB + 7) / 8) * 8;
  localparam int AXW  = (AXIS_COUNT > 1) ? $clog2(AXIS_COUNT) : 1;

  localparam logic signed [AW-1:0] Y_HALF = AW'(1) << (COEF_FRAC_BITS - 1);

  tbql_ctl_t ctl;
  logic [AXW-1:0] axis;
  logic in_fire;
  logic out_free;

  // coefficient registers
  logic signed [CW-1:0] gain_r, b0_r, b1_r, b2_r, a1_r, a2_r;

  // per-axis history and latched samples
  logic signed [SB-1:0]  xin_r     [AXIS_COUNT];
  logic signed [SB-1:0]  in_one_r  [AXIS_COUNT];
  logic signed [SB-1:0]  in_two_r  [AXIS_COUNT];
  logic signed [STW-1:0] out_one_r [AXIS_COUNT];
  logic signed [STW-1:0] out_two_r [AXIS_COUNT];
  logic        [SB-1:0]  res_r     [AXIS_COUNT];
  logic                  clip_r;

  logic signed [AW-1:0]  acc_r;
  logic signed [SRW-1:0] sr_r;
  logic signed [SRW-1:0] sr_val;
  logic signed [AW-1:0]  prod;
  logic signed [CW-1:0]  coef_sel;
  logic signed [OPW-1:0] opnd_sel;

  logic signed [AW-1:0]  y_biased;
  logic signed [AW-1:0]  y_wide;
  logic                  y_ovf;
  logic signed [STW-1:0] y_sat;
  logic        [SB-1:0]  o_sat;
  logic                  o_ovf;

  logic          out_valid_r;
  logic [DW-1:0] out_data_r;
  logic          out_clip_r;
  logic [DW-1:0] out_data_nxt;

  assign in_tready = ctl.idle;
  assign in_fire   = in_tvalid && ctl.idle;
  assign out_free  = !out_valid_r || out_tready;

  tbql_seq #(
    .AXIS_COUNT (AXIS_COUNT),
    .NX         (NX),
    .NY         (NY),
    .NS         (NS),
    .AXW        (AXW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .ctl      (ctl),
    .axis     (axis)
  );

  tbql_mult #(
    .CW  (CW),
    .D   (D),
    .OPW (OPW),
    .NX  (NX),
    .NY  (NY),
    .NS  (NS),
    .AW  (AW)
  ) u_mult (
    .clk     (clk),
    .ctl     (ctl),
    .coef    (coef_sel),
    .operand (opnd_sel),
    .prod    (prod)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= RST_GAIN;
      b0_r   <= RST_B0;
      b1_r   <= RST_B1;
      b2_r   <= RST_B2;
      a1_r   <= RST_A1;
      a2_r   <= RST_A2;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_GAIN: gain_r <= cfg_wdata;
        REG_B0:   b0_r   <= cfg_wdata;
        REG_B1:   b1_r   <= cfg_wdata;
        REG_B2:   b2_r   <= cfg_wdata;
        REG_A1:   a1_r   <= cfg_wdata;
        REG_A2:   a2_r   <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  // operand and coefficient for the current phase
  always_comb begin
    unique case (ctl.phase)
      PH_B0: begin
        coef_sel = b0_r;
        opnd_sel = OPW'(xin_r[axis]);
      end
      PH_B1: begin
        coef_sel = b1_r;
        opnd_sel = OPW'(in_one_r[axis]);
      end
      PH_B2: begin
        coef_sel = b2_r;
        opnd_sel = OPW'(in_two_r[axis]);
      end
      PH_GAIN: begin
        coef_sel = gain_r;
        opnd_sel = OPW'(sr_r);
      end
      PH_A1: begin
        coef_sel = a1_r;
        opnd_sel = OPW'(out_one_r[axis]);
      end
      PH_A2: begin
        coef_sel = a2_r;
        opnd_sel = OPW'(out_two_r[axis]);
      end
      default: begin
        coef_sel = b0_r;
        opnd_sel = OPW'(xin_r[axis]);
      end
    endcase
  end

  // feedforward sum down to state precision
  generate
    if (RSH > 0) begin : g_ff_round
      localparam logic signed [AW-1:0] FF_HALF = AW'(1) << (RSH - 1);
      logic signed [AW-1:0] ff_biased;
      assign ff_biased = acc_r + FF_HALF;
      assign sr_val    = SRW'(ff_biased >>> RSH);
    end else begin : g_ff_scale
      assign sr_val = SRW'(acc_r <<< (-RSH));
    end
  endgenerate

  // new state: round, then saturate to STW bits
  always_comb begin
    y_biased = acc_r + Y_HALF;
    y_wide   = y_biased >>> COEF_FRAC_BITS;
    y_ovf    = !((&y_wide[AW-1:STW-1]) || !(|y_wide[AW-1:STW-1]));
    if (y_ovf) begin
      y_sat = y_wide[AW-1] ? {1'b1, {(STW-1){1'b0}}} : {1'b0, {(STW-1){1'b1}}};
    end else begin
      y_sat = y_wide[STW-1:0];
    end
  end

  // output: drop state fraction bits, then saturate to SB bits
  generate
    if (SFB > 0) begin : g_out_round
      localparam logic [STW:0] O_HALF = (STW + 1)'(1) << (SFB - 1);
      logic [STW:0]  o_biased;
      logic [SB:0]   o_wide;
      always_comb begin
        o_biased = {y_sat[STW-1], y_sat} + O_HALF;
        o_wide   = o_biased[STW:SFB];
        o_ovf    = o_wide[SB] ^ o_wide[SB-1];
        if (o_ovf) begin
          o_sat = o_wide[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end else begin
          o_sat = o_wide[SB-1:0];
        end
      end
    end else begin : g_out_pass
      assign o_sat = y_sat;
      assign o_ovf = 1'b0;
    end
  endgenerate

  // accumulator and rounded feedforward sum
  always_ff @(posedge clk) begin
    if (in_fire || ctl.do_round || ctl.do_finish) begin
      acc_r <= '0;
    end else if (ctl.acc_add) begin
      if (ctl.phase == PH_A1 || ctl.phase == PH_A2) begin
        acc_r <= acc_r - prod;
      end else begin
        acc_r <= acc_r + prod;
      end
    end
    if (ctl.do_round) begin
      sr_r <= sr_val;
    end
  end

  // latch samples on acceptance
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        xin_r[a] <= in_tdata[a*SB +: SB];
      end
    end
  end

  // history update at the end of each axis
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXIS_COUNT; a++) begin
        in_one_r[a]  <= '0;
        in_two_r[a]  <= '0;
        out_one_r[a] <= '0;
        out_two_r[a] <= '0;
      end
    end else if (ctl.do_finish) begin
      in_two_r[axis]  <= in_one_r[axis];
      in_one_r[axis]  <= xin_r[axis];
      out_two_r[axis] <= out_one_r[axis];
      out_one_r[axis] <= y_sat;
    end
  end

  // per-item results and clip flag
  always_ff @(posedge clk) begin
    if (in_fire) begin
      clip_r <= 1'b0;
    end else if (ctl.do_finish) begin
      clip_r <= clip_r | y_ovf | o_ovf;
    end
    if (ctl.do_finish) begin
      res_r[axis] <= o_sat;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    for (int a = 0; a < AXIS_COUNT; a++) begin
      out_data_nxt[a*SB +: SB] = res_r[a];
    end
  end

  // output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.do_push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_push) begin
      out_data_r <= out_data_nxt;
      out_clip_r <= clip_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_clip_r;

endmodule

// ===== rtl/core/tbql_mult.sv =====
// Digit-serial signed multiplier: coefficient times operand, one digit per cycle.
module tbql_mult #(
  parameter int CW  = tbql_pkg::COEF_BITS,
  parameter int D   = tbql_pkg::DIGIT_BITS,
  parameter int OPW = 32,
  parameter int NX  = 4,
  parameter int NY  = 6,
  parameter int NS  = 8,
  parameter int AW  = 63
) (
  input  logic                    clk,
  input  tbql_pkg::tbql_ctl_t     ctl,
  input  logic signed [CW-1:0]    coef,
  input  logic signed [OPW-1:0]   operand,
  output logic signed [AW-1:0]    prod
);
  import tbql_pkg::*;

  localparam int HW = CW + D + 1;

  logic signed [HW-1:0]     hi_r;
  logic        [OPW-1:0]    lo_r;
  logic        [D-1:0]      dig;
  logic        [D:0]        dsig;
  logic signed [HW-1:0]     partial;
  logic signed [HW-1:0]     sum;
  logic signed [HW+OPW-1:0] full;

  always_comb begin
    dig     = lo_r[D-1:0];
    // top digit of the operand carries its sign
    dsig    = ctl.mul_last ? {dig[D-1], dig} : {1'b0, dig};
    partial = coef * $signed(dsig);
    sum     = hi_r + partial;
  end

  always_ff @(posedge clk) begin
    if (ctl.mul_load) begin
      hi_r <= '0;
      lo_r <= operand;
    end else if (ctl.mul_step) begin
      hi_r <= sum >>> D;
      lo_r <= {sum[D-1:0], lo_r[OPW-1:D]};
    end
  end

  assign full = {hi_r, lo_r};

  // unconsumed operand digits sit below the product; drop them
  always_comb begin
    case (ctl.kind)
      KIND_SAMPLE: prod = AW'(full >>> (OPW - NX * D));
      KIND_SUM:    prod = AW'(full >>> (OPW - NS * D));
      KIND_STATE:  prod = AW'(full >>> (OPW - NY * D));
      default:     prod = AW'(full >>> (OPW - NS * D));
    endcase
  end

endmodule

// ===== rtl/core/tbql_seq.sv =====
// Sequencer: walks axes, multiply phases and digits for one item.
module tbql_seq #(
  parameter int AXIS_COUNT = tbql_pkg::TBQL_AXIS_COUNT,
  parameter int NX         = 4,
  parameter int NY         = 6,
  parameter int NS         = 8,
  parameter int AXW        = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_free,
  output tbql_pkg::tbql_ctl_t ctl,
  output logic [AXW-1:0]      axis
);
  import tbql_pkg::*;

  localparam int NMAX = (NX > NY) ? ((NX > NS) ? NX : NS) : ((NY > NS) ? NY : NS);
  localparam int DGW  = $clog2(NMAX);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_LOAD  = 3'd1;
  localparam logic [2:0] ST_STEP  = 3'd2;
  localparam logic [2:0] ST_ACC   = 3'd3;
  localparam logic [2:0] ST_ROUND = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;
  localparam logic [2:0] ST_PUSH  = 3'd6;

  logic [2:0]     state_r, state_nxt;
  logic [2:0]     ph_r, ph_nxt;
  logic [DGW-1:0] dig_r, dig_nxt;
  logic [AXW-1:0] axis_r, axis_nxt;
  logic [1:0]     kind;
  logic [DGW-1:0] dig_end;

  always_comb begin
    unique case (ph_r) inside
      PH_B0, PH_B1, PH_B2: kind = KIND_SAMPLE;
      PH_GAIN:             kind = KIND_SUM;
      default:             kind = KIND_STATE;
    endcase
    case (kind)
      KIND_SAMPLE: dig_end = DGW'(NX - 1);
      KIND_SUM:    dig_end = DGW'(NS - 1);
      default:     dig_end = DGW'(NY - 1);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    dig_nxt   = dig_r;
    axis_nxt  = axis_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_LOAD;
          ph_nxt    = PH_B0;
          axis_nxt  = '0;
        end
      end
      ST_LOAD: begin
        state_nxt = ST_STEP;
        dig_nxt   = '0;
      end
      ST_STEP: begin
        if (dig_r == dig_end) begin
          state_nxt = ST_ACC;
        end else begin
          dig_nxt = dig_r + 1'b1;
        end
      end
      ST_ACC: begin
        if (ph_r == PH_B2) begin
          state_nxt = ST_ROUND;
        end else if (ph_r == PH_A2) begin
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_LOAD;
          ph_nxt    = ph_r + 1'b1;
        end
      end
      ST_ROUND: begin
        state_nxt = ST_LOAD;
        ph_nxt    = PH_GAIN;
      end
      ST_FIN: begin
        if (axis_r == AXW'(AXIS_COUNT - 1)) begin
          state_nxt = ST_PUSH;
        end else begin
          state_nxt = ST_LOAD;
          ph_nxt    = PH_B0;
          axis_nxt  = axis_r + 1'b1;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ph_r    <= PH_B0;
      dig_r   <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
      dig_r   <= dig_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    ctl.idle      = (state_r == ST_IDLE);
    ctl.mul_load  = (state_r == ST_LOAD);
    ctl.mul_step  = (state_r == ST_STEP);
    ctl.mul_last  = (state_r == ST_STEP) && (dig_r == dig_end);
    ctl.kind      = kind;
    ctl.phase     = ph_r;
    ctl.acc_add   = (state_r == ST_ACC);
    ctl.do_round  = (state_r == ST_ROUND);
    ctl.do_finish = (state_r == ST_FIN);
    ctl.do_push   = (state_r == ST_PUSH) && out_free;
  end

  assign axis = axis_r;

endmodule
